### rtl/djs_pkg.sv
// Shared types and constants of the deadline job scheduler.
`timescale 1ns / 1ps
package djs_pkg;

   localparam int PROFIT_W   = 31;
   localparam int DEADLINE_W = 16;
   localparam int HORIZON_W  = 10;
   localparam int TOTAL_W    = 41;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 48;

   localparam logic [HORIZON_W-1:0] HORIZON_RESET = 10'd1023;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_LOAD,
      ST_SORT_FETCH,
      ST_SORT_GRAB,
      ST_SORT_CMP,
      ST_SORT_PUT,
      ST_PLACE_FETCH,
      ST_PLACE_GRAB,
      ST_PLACE_TEST,
      ST_EMIT
   } state_type;

endpackage

### rtl/djs_ram.sv
// Simple dual-port synchronous RAM with a registered read port.
`timescale 1ns / 1ps
module djs_ram
   import djs_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

### rtl/deadline_job_scheduler.sv
// Top level of the deadline job scheduler: job store, sorter and slot placer.
`timescale 1ns / 1ps
// Usage. Jobs arrive on the req_ stream, one per transaction, with the profit
// and deadline packed in req_tdata and req_tlast marking the final job of a set.
// Each job is stored as it is accepted, up to MAX_JOBS; further jobs are
// dropped and set the overflow flag. The final transaction starts the work on
// the set: the stored jobs are insertion sorted in the job memory by falling
// profit and rising deadline, then each job probes the slot memory downward
// from its deadline, clamped to the horizon. After that the total profit and
// the overflow flag are presented on the rsp_ stream, and the slot memory is
// swept clear before the next job is accepted. The result sits in an output
// register, so the sweep runs while the receiver stalls; only a second result
// waits for the first to be taken. Reset runs the same clearing sweep, during
// which req_tready stays low. The horizon register is written through the csr_
// channel, which is always ready, and must only be written while the block is
// idle.
module deadline_job_scheduler
   import djs_pkg::*;
#(
   parameter int MAX_JOBS  = 1024,
   parameter int MAX_SLOTS = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // job_profit[30:0], job_deadline[46:31], zero
   input  logic                  req_tlast,  // last_job
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // total_profit[40:0], zero
   output logic                  rsp_tuser,  // overflow
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [HORIZON_W-1:0]  csr_data    // horizon
);

   localparam int JOB_AW  = $clog2(MAX_JOBS);
   localparam int CNT_W   = $clog2(MAX_JOBS + 1);
   localparam int SLOT_W  = $clog2(MAX_SLOTS);
   localparam int REC_W   = PROFIT_W + SLOT_W;
   localparam logic [16:0]       SLOT_MAX17 = 17'(MAX_SLOTS - 1);
   localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(MAX_SLOTS - 1);
   localparam logic [CNT_W-1:0]  CNT_FULL   = CNT_W'(MAX_JOBS);

   // A job record keeps the profit in the upper bits, the clamped deadline below.
   function automatic logic goes_first(input logic [REC_W-1:0] x, input logic [REC_W-1:0] y);
      logic [PROFIT_W-1:0] px, py;
      logic [SLOT_W-1:0]   dx, dy;
      px = x[REC_W-1:SLOT_W];
      py = y[REC_W-1:SLOT_W];
      dx = x[SLOT_W-1:0];
      dy = y[SLOT_W-1:0];
      return (px > py) || ((px == py) && (dx < dy));
   endfunction

   state_type state_ff, state_in;

   logic [HORIZON_W-1:0] horizon_ff, horizon_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [CNT_W-1:0]     i_ff, i_in;
   logic [CNT_W-1:0]     k_ff, k_in;
   logic [REC_W-1:0]     key_ff, key_in;
   logic [PROFIT_W-1:0]  p_ff, p_in;
   logic [SLOT_W-1:0]    s_ff, s_in;
   logic [SLOT_W-1:0]    clr_ff, clr_in;
   logic [TOTAL_W-1:0]   total_ff, total_in;
   logic                 drop_ff, drop_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [TOTAL_W-1:0]   rsp_total_ff, rsp_total_in;
   logic                 rsp_ovf_ff, rsp_ovf_in;

   // Job memory ports.
   logic              jw_en;
   logic [JOB_AW-1:0] jw_addr;
   logic [REC_W-1:0]  jw_data;
   logic [JOB_AW-1:0] jr_addr;
   logic [REC_W-1:0]  jr_data;

   // Slot memory ports.
   logic              sw_en;
   logic [SLOT_W-1:0] sw_addr;
   logic [0:0]        sw_data;
   logic [SLOT_W-1:0] sr_addr;
   logic [0:0]        sr_data;

   logic [CNT_W-1:0]    i_m1, k_m1, k_m2, i_p1;
   logic [16:0]         limit17, dline17;
   logic [SLOT_W-1:0]   limit, dclamp, job_d, start_slot;
   logic [PROFIT_W-1:0] req_profit;
   logic [DEADLINE_W-1:0] req_deadline;
   logic                req_fire, cnt_done, emit_go;

   djs_ram #(.WIDTH(REC_W), .DEPTH(MAX_JOBS)) u_job_ram (
      .clock   (clock),
      .wr_en   (jw_en),
      .wr_addr (jw_addr),
      .wr_data (jw_data),
      .rd_addr (jr_addr),
      .rd_data (jr_data)
   );

   djs_ram #(.WIDTH(1), .DEPTH(MAX_SLOTS)) u_slot_ram (
      .clock   (clock),
      .wr_en   (sw_en),
      .wr_addr (sw_addr),
      .wr_data (sw_data),
      .rd_addr (sr_addr),
      .rd_data (sr_data)
   );

   assign req_profit   = req_tdata[PROFIT_W-1:0];
   assign req_deadline = req_tdata[PROFIT_W+DEADLINE_W-1:PROFIT_W];
   assign req_tready   = (state_ff == ST_LOAD);
   assign req_fire     = req_tvalid && req_tready;
   assign csr_ready    = 1'b1;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - TOTAL_W){1'b0}}, rsp_total_ff};
   assign rsp_tuser  = rsp_ovf_ff;

   assign i_m1 = i_ff - CNT_W'(1);
   assign i_p1 = i_ff + CNT_W'(1);
   assign k_m1 = k_ff - CNT_W'(1);
   assign k_m2 = k_ff - CNT_W'(2);

   // Clamp the deadline to the slot range and the horizon to the last slot.
   assign dline17    = {1'b0, req_deadline};
   assign dclamp     = (dline17 > SLOT_MAX17) ? SLOT_LAST : dline17[SLOT_W-1:0];
   assign limit17    = {{(17 - HORIZON_W){1'b0}}, horizon_ff};
   assign limit      = (limit17 > SLOT_MAX17) ? SLOT_LAST : limit17[SLOT_W-1:0];
   assign job_d      = jr_data[SLOT_W-1:0];
   assign start_slot = (job_d > limit) ? limit : job_d;

   assign cnt_done = (i_ff >= cnt_ff);
   assign emit_go  = !rsp_valid_ff || rsp_tready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == SLOT_LAST) state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (req_fire && req_tlast) state_in = ST_SORT_FETCH;
         end
         ST_SORT_FETCH: begin
            state_in = cnt_done ? ST_PLACE_FETCH : ST_SORT_GRAB;
         end
         ST_SORT_GRAB: begin
            state_in = ST_SORT_CMP;
         end
         ST_SORT_CMP: begin
            if (!goes_first(key_ff, jr_data)) begin
               state_in = ST_SORT_FETCH;
            end else if (k_ff == CNT_W'(1)) begin
               state_in = ST_SORT_PUT;
            end
         end
         ST_SORT_PUT: begin
            state_in = ST_SORT_FETCH;
         end
         ST_PLACE_FETCH: begin
            state_in = cnt_done ? ST_EMIT : ST_PLACE_GRAB;
         end
         ST_PLACE_GRAB: begin
            state_in = ST_PLACE_TEST;
         end
         ST_PLACE_TEST: begin
            if (!sr_data[0] || (s_ff == '0)) state_in = ST_PLACE_FETCH;
         end
         ST_EMIT: begin
            if (emit_go) state_in = ST_CLEAR;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // Datapath and memory controls.
   always_comb begin
      horizon_in   = horizon_ff;
      cnt_in       = cnt_ff;
      i_in         = i_ff;
      k_in         = k_ff;
      key_in       = key_ff;
      p_in         = p_ff;
      s_in         = s_ff;
      clr_in       = clr_ff;
      total_in     = total_ff;
      drop_in      = drop_ff;
      rsp_total_in = rsp_total_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      jw_en   = 1'b0;
      jw_addr = '0;
      jw_data = '0;
      jr_addr = '0;
      sw_en   = 1'b0;
      sw_addr = '0;
      sw_data = 1'b0;
      sr_addr = '0;

      if (csr_valid) horizon_in = csr_data;

      case (state_ff)
         ST_CLEAR: begin
            sw_en   = 1'b1;
            sw_addr = clr_ff;
            clr_in  = clr_ff + SLOT_W'(1);
         end
         ST_LOAD: begin
            if (req_fire) begin
               if (cnt_ff < CNT_FULL) begin
                  jw_en   = 1'b1;
                  jw_addr = cnt_ff[JOB_AW-1:0];
                  jw_data = {req_profit, dclamp};
                  cnt_in  = cnt_ff + CNT_W'(1);
               end else begin
                  drop_in = 1'b1;
               end
               i_in = CNT_W'(1);
            end
         end
         ST_SORT_FETCH: begin
            jr_addr = i_ff[JOB_AW-1:0];
            if (cnt_done) i_in = '0;
         end
         ST_SORT_GRAB: begin
            key_in  = jr_data;
            k_in    = i_ff;
            jr_addr = i_m1[JOB_AW-1:0];
         end
         ST_SORT_CMP: begin
            jw_en   = 1'b1;
            jw_addr = k_ff[JOB_AW-1:0];
            if (goes_first(key_ff, jr_data)) begin
               // Shift the earlier record up one place and look further down.
               jw_data = jr_data;
               k_in    = k_m1;
               jr_addr = k_m2[JOB_AW-1:0];
            end else begin
               jw_data = key_ff;
               i_in    = i_p1;
            end
         end
         ST_SORT_PUT: begin
            jw_en   = 1'b1;
            jw_addr = k_ff[JOB_AW-1:0];
            jw_data = key_ff;
            i_in    = i_p1;
         end
         ST_PLACE_FETCH: begin
            jr_addr = i_ff[JOB_AW-1:0];
         end
         ST_PLACE_GRAB: begin
            p_in    = jr_data[REC_W-1:SLOT_W];
            s_in    = start_slot;
            sr_addr = start_slot;
         end
         ST_PLACE_TEST: begin
            if (!sr_data[0]) begin
               sw_en    = 1'b1;
               sw_addr  = s_ff;
               sw_data  = 1'b1;
               total_in = total_ff + {{(TOTAL_W - PROFIT_W){1'b0}}, p_ff};
               i_in     = i_p1;
            end else if (s_ff == '0) begin
               // No free slot at or below the deadline: the job is skipped.
               i_in = i_p1;
            end else begin
               s_in    = s_ff - SLOT_W'(1);
               sr_addr = s_ff - SLOT_W'(1);
            end
         end
         ST_EMIT: begin
            if (emit_go) begin
               rsp_valid_in = 1'b1;
               rsp_total_in = total_ff;
               rsp_ovf_in   = drop_ff;
               cnt_in       = '0;
               total_in     = '0;
               drop_in      = 1'b0;
               clr_in       = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         horizon_ff   <= HORIZON_RESET;
         cnt_ff       <= '0;
         i_ff         <= '0;
         k_ff         <= '0;
         clr_ff       <= '0;
         total_ff     <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         horizon_ff   <= horizon_in;
         cnt_ff       <= cnt_in;
         i_ff         <= i_in;
         k_ff         <= k_in;
         clr_ff       <= clr_in;
         total_ff     <= total_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      p_ff         <= p_in;
      s_ff         <= s_in;
      rsp_total_ff <= rsp_total_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

endmodule
